>>> rtl/core/dws_pkg.sv
// Shared constants and types of the dictionary substitution block.
package dws_pkg;

	localparam int ENTRIES  = 16;
	localparam int MAX_WORD = 8;
	localparam int MAX_CODE = 8;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int POS_W  = 3;
	localparam int LEN_W  = $clog2(MAX_WORD + 1);
	localparam int KC_W   = $clog2(MAX_CODE + 1);
	localparam int CNT_W  = 5;

	typedef enum logic [1:0] {
		ACT_DICT  = 2'd0,
		ACT_CHAR  = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_SCAN,
		ST_EMIT,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	// dictionary byte write broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic             side;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
	} wr_t;

	// decision token handed from cell to cell
	typedef struct packed {
		logic                       vld;
		logic                       hit;
		logic [LEN_W-1:0]           len;
		logic [MAX_CODE-1:0][7:0]   code;
	} chain_t;

endpackage

>>> rtl/core/dws_cell.sv
// One dictionary entry cell: holds its word and code, matches the window, passes the token on.
module dws_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [dws_pkg::IDX_W-1:0]              idx,
	input  dws_pkg::wr_t                           wr,
	input  logic [dws_pkg::CNT_W-1:0]              entry_count,
	input  logic [dws_pkg::MAX_WORD-1:0][7:0]      window,
	input  logic [dws_pkg::LEN_W-1:0]              fill,
	input  dws_pkg::chain_t                        cin,
	output dws_pkg::chain_t                        cout
);
	import dws_pkg::*;

	logic [MAX_WORD-1:0][7:0] word_q;
	logic [MAX_CODE-1:0][7:0] code_q;
	logic [LEN_W-1:0]         wl;
	logic                     eq;
	logic                     match;
	chain_t                   cout_d;
	chain_t                   cout_q;

	// store dictionary bytes addressed to this entry
	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == idx) begin
			if (!wr.side)
				word_q[wr.pos] <= wr.data;
			else
				code_q[wr.pos] <= wr.data;
		end
	end

	// word length: first zero byte
	always_comb begin
		wl = LEN_W'(MAX_WORD);
		for (int k = MAX_WORD - 1; k >= 0; k--) begin
			if (word_q[k] == 8'd0)
				wl = LEN_W'(k);
		end
	end

	// compare the word against the head of the window
	always_comb begin
		eq = 1'b1;
		for (int k = 0; k < MAX_WORD; k++) begin
			if (LEN_W'(k) < wl && word_q[k] != window[k])
				eq = 1'b0;
		end
		match = ({1'b0, idx} < entry_count) && (wl != '0) && (wl <= fill) && eq;
	end

	// the first matching entry claims the token
	always_comb begin
		cout_d = cin;
		if (cin.vld && !cin.hit && match) begin
			cout_d.hit  = 1'b1;
			cout_d.len  = wl;
			cout_d.code = code_q;
		end
	end

	// advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout_q <= '0;
		end else begin
			cout_q <= cout_d;
		end
	end

	assign cout = cout_q;

endmodule

>>> rtl/core/dictionary_word_substitution.sv
// Top level of the dictionary substitution block: window, control and output stage.
//
// Usage: the s_ channel carries requests. s_tuser holds the action (dictionary
// byte write, text character, end of line flush); s_tdata holds entry index,
// table side, byte position and the byte. The m_ channel returns emitted
// characters in m_tdata, with m_tlast on the final character caused by a request.
// entry_count is set over the APB port at address 0; write it only while the
// block is idle, as the block itself does not enforce this. A dictionary write
// leaves the block idle. A character that fills the eight-byte window, and each
// decision of a flush, launch a token down the chain of ENTRIES cells: a launch
// step, then through the token register of each cell in turn. The decision then
// emits the code characters of the hit, or passes the head character through,
// waiting while the output is stalled, then shifts the window; a finish step closes the request.
// A character that leaves the window short of full is stored and the block stays idle.
// One request is in work at a time; s_tready is high only when idle.
// The last character is held in a pending register so it can be marked with tlast.
// When the receiver stalls, the output register holds and the block waits.
// Reset empties the window, clears entry_count and the output stage; the
// dictionary contents are undefined until written.
module dictionary_word_substitution (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // entry_index[3:0], table_side[4], char_pos[7:5], byte_req[15:8]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_char[7:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dws_pkg::*;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         entry_count_q;
	logic [MAX_WORD-1:0][7:0] win_q;
	logic [LEN_W-1:0]         fill_q;
	logic                     flush_q;
	logic                     hit_q;
	logic [LEN_W-1:0]         len_q;
	logic [MAX_CODE-1:0][7:0] code_q;
	logic [KC_W-1:0]          k_q;
	logic                     pend_valid_q;
	logic [7:0]               pend_q;
	logic                     m_tvalid_q;
	logic [7:0]               m_tdata_q;
	logic                     m_tlast_q;

	logic                     s_acc;
	action_t                  act;
	wr_t                      wr;
	chain_t                   link [ENTRIES+1];
	logic                     launch;
	logic                     out_free;
	logic                     can_prod;
	logic                     code_end;
	logic                     produce;
	logic [7:0]               prod_byte;
	logic                     push_out;
	logic                     push_last;
	logic                     shift_en;
	logic [LEN_W-1:0]         used;
	logic [LEN_W-1:0]         fill_after;

	assign act   = action_t'(s_tuser);
	assign s_acc = s_tvalid && s_tready;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {{(32-CNT_W){1'b0}}, entry_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_count_q <= '0;
		else if (psel && penable && pwrite && pready && paddr == 3'd0)
			entry_count_q <= pwdata[CNT_W-1:0];
	end

	// dictionary write broadcast
	assign wr.en   = s_acc && act == ACT_DICT;
	assign wr.idx  = s_tdata[3:0];
	assign wr.side = s_tdata[4];
	assign wr.pos  = s_tdata[7:5];
	assign wr.data = s_tdata[15:8];

	// chain of entry cells
	assign link[0] = '{vld: launch, hit: 1'b0, len: '0, code: '0};

	for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
		dws_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(e)),
			.wr         (wr),
			.entry_count(entry_count_q),
			.window     (win_q),
			.fill       (fill_q),
			.cin        (link[e]),
			.cout       (link[e+1])
		);
	end

	assign out_free   = !m_tvalid_q || m_tready;
	assign can_prod   = !pend_valid_q || out_free;
	assign code_end   = (k_q == KC_W'(MAX_CODE)) || (code_q[k_q[POS_W-1:0]] == 8'd0);
	assign used       = hit_q ? len_q : LEN_W'(1);
	assign fill_after = fill_q - used;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (act == ACT_CHAR && fill_q == LEN_W'(MAX_WORD - 1))
						state_d = ST_LAUNCH;
					else if (act == ACT_FLUSH && fill_q != '0)
						state_d = ST_LAUNCH;
				end
			end
			ST_LAUNCH: state_d = ST_SCAN;
			ST_SCAN: begin
				if (link[ENTRIES].vld)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (hit_q ? code_end : can_prod)
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (flush_q && fill_after != '0)
					state_d = ST_LAUNCH;
				else
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!pend_valid_q || out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		launch    = 1'b0;
		produce   = 1'b0;
		prod_byte = win_q[0];
		push_last = 1'b0;
		shift_en  = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_LAUNCH: launch = 1'b1;
			ST_SCAN:   ;
			ST_EMIT: begin
				if (hit_q) begin
					prod_byte = code_q[k_q[POS_W-1:0]];
					produce   = !code_end && can_prod;
				end else begin
					produce   = can_prod;
				end
			end
			ST_SHIFT:  shift_en = 1'b1;
			ST_FINISH: push_last = pend_valid_q && out_free;
			default:   ;
		endcase
	end

	assign push_out = (produce && pend_valid_q) || push_last;

	// state, window and decision registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= '0;
			fill_q  <= '0;
			flush_q <= 1'b0;
			hit_q   <= 1'b0;
			len_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				flush_q <= (act == ACT_FLUSH);
				if (act == ACT_CHAR && fill_q < LEN_W'(MAX_WORD)) begin
					win_q[fill_q[POS_W-1:0]] <= s_tdata[15:8];
					fill_q <= fill_q + LEN_W'(1);
				end
			end
			if (state_q == ST_SCAN && link[ENTRIES].vld) begin
				hit_q <= link[ENTRIES].hit;
				len_q <= link[ENTRIES].len;
				k_q   <= '0;
			end
			if (produce && hit_q)
				k_q <= k_q + KC_W'(1);
			// drop the decided bytes from the head of the window
			if (shift_en) begin
				for (int j = 0; j < MAX_WORD; j++) begin
					if ((LEN_W + 1)'(j) + (LEN_W + 1)'(used) < (LEN_W + 1)'(fill_q))
						win_q[j] <= win_q[POS_W'(j) + used[POS_W-1:0]];
					else
						win_q[j] <= 8'd0;
				end
				fill_q <= fill_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && link[ENTRIES].vld)
			code_q <= link[ENTRIES].code;
	end

	// pending character and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tlast_q    <= 1'b0;
		end else begin
			if (produce)
				pend_valid_q <= 1'b1;
			else if (push_last)
				pend_valid_q <= 1'b0;
			if (push_out) begin
				m_tvalid_q <= 1'b1;
				m_tlast_q  <= push_last;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce)
			pend_q <= prod_byte;
		if (push_out)
			m_tdata_q <= pend_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(MAX_WORD))
		else $error("window fill out of range");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("character left pending while idle");
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		link[ENTRIES].vld |-> state_q == ST_SCAN)
		else $error("chain token arrived outside scan");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready |-> !push_out)
		else $error("output register overwritten while stalled");

endmodule

>>> tb/sv/tb_dictionary_word_substitution.sv
// Testbench for the dictionary substitution block: directed and random requests, scoreboard check.
`timescale 1ns / 100ps

class subst_scoreboard;
	byte unsigned words [16][8];
	byte unsigned codes [16][8];
	byte unsigned window [8];
	int fill;
	int entry_count;
	byte unsigned exp_char [$];
	bit exp_last [$];
	int errors;

	function new();
		foreach (words[i, k]) begin
			words[i][k] = 0;
			codes[i][k] = 0;
		end
		foreach (window[k]) window[k] = 0;
		fill = 0;
		entry_count = 0;
		errors = 0;
	endfunction

	function int word_len(int e);
		int k;
		k = 0;
		while (k < 8 && words[e][k] != 0) k++;
		return k;
	endfunction

	// decide at the window head and append emitted characters
	function int decide_head();
		int lim, used, wl, n;
		bit hit, same;
		lim = (entry_count < 16) ? entry_count : 16;
		used = 1;
		hit = 0;
		n = 0;
		for (int e = 0; e < lim && !hit; e++) begin
			wl = word_len(e);
			if (wl == 0 || wl > fill) continue;
			same = 1;
			for (int k = 0; k < wl; k++)
				if (words[e][k] != window[k]) same = 0;
			if (same) begin
				hit = 1;
				used = wl;
				for (int k = 0; k < 8; k++) begin
					if (codes[e][k] == 0) break;
					exp_char.push_back(codes[e][k]);
					exp_last.push_back(0);
					n++;
				end
			end
		end
		if (!hit) begin
			exp_char.push_back(window[0]);
			exp_last.push_back(0);
			n++;
		end
		for (int k = 0; k < 8; k++)
			window[k] = (k + used < fill) ? window[k + used] : 8'd0;
		fill -= used;
		return n;
	endfunction

	// note an accepted request
	function void note_request(logic [1:0] act, logic [3:0] idx, logic side,
			logic [2:0] pos, logic [7:0] b);
		int n;
		n = 0;
		if (act == dws_pkg::ACT_DICT) begin
			if (side) codes[idx][pos] = b;
			else words[idx][pos] = b;
		end else if (act == dws_pkg::ACT_CHAR) begin
			if (fill < 8) begin
				window[fill] = b;
				fill++;
			end
			while (fill >= 8) n += decide_head();
		end else if (act == dws_pkg::ACT_FLUSH) begin
			while (fill > 0) n += decide_head();
		end
		if (n > 0) exp_last[$] = 1;
	endfunction

	// check one emitted character
	function void check_char(logic [7:0] c, logic l);
		if (exp_char.size() == 0) begin
			$error("unexpected out_char %0h", c);
			errors++;
			return;
		end
		if (exp_char[0] != c) begin
			$error("out_char expected %0h actual %0h", exp_char[0], c);
			errors++;
		end
		if (exp_last[0] != l) begin
			$error("last_of_run expected %0b actual %0b", exp_last[0], l);
			errors++;
		end
		void'(exp_char.pop_front());
		void'(exp_last.pop_front());
	endfunction
endclass

module tb_dictionary_word_substitution;
	import dws_pkg::*;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [15:0] s_tdata;   // entry_index[3:0], table_side[4], char_pos[7:5], byte_req[15:8]
	logic [1:0] s_tuser;    // action[1:0]
	logic [7:0] m_tdata;    // out_char[7:0]
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	subst_scoreboard board;
	int idle_pct;
	int stall_cycles;
	bit done;
	string txt;

	dictionary_word_substitution i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// drain results with random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) board.check_char(m_tdata, m_tlast);
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// watchdog on cycles without any accepted transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || done)
			stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(logic [1:0] act, logic [3:0] idx, logic side,
			logic [2:0] pos, logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {b, pos, side, idx};
		do @(posedge clk); while (!s_tready);
		board.note_request(act, idx, side, pos, b);
	endtask

	task automatic put_word(int e, logic side, string s);
		for (int k = 0; k < 8; k++)
			send(ACT_DICT, 4'(e), side, 3'(k), (k < s.len()) ? s[k] : 8'd0);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (board.exp_char.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_count(int v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		board.entry_count = v & 5'h1f;
	endtask

	// text drawn mostly from the small alphabet the dictionary uses
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 80) return 8'(8'h61 + $urandom_range(3));
		return 8'($urandom_range(255));
	endfunction

	task automatic random_phase(int n);
		int r, e;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 72) send(ACT_CHAR, 4'($urandom), 1'($urandom), 3'($urandom), pick_char());
			else if (r < 84)
				send(ACT_FLUSH, 4'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
			else if (r < 88)
				send(ACT_NONE, 4'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
			else begin
				// rewrite a byte of a fully written entry so every read stays defined
				e = $urandom_range(4);
				send(ACT_DICT, 4'(e), 1'($urandom), 3'($urandom),
					($urandom_range(3) == 0) ? 8'd0 : pick_char());
			end
		end
		send(ACT_FLUSH, '0, '0, '0, '0);
	endtask

	initial begin
		board = new();
		idle_pct = 14;
		done = 0;
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// entries past the loaded ones get an empty word so they never match
		for (int e = 5; e < 16; e++)
			send(ACT_DICT, 4'(e), 1'b0, 3'd0, 8'd0);
		put_word(0, 0, "ab");    put_word(0, 1, "X");
		put_word(1, 0, "abc");   put_word(1, 1, "YYYYYYYY");
		put_word(2, 0, "c");     put_word(2, 1, "");
		put_word(3, 0, "dddddddd"); put_word(3, 1, "Z");
		put_word(4, 0, "\377\001"); put_word(4, 1, "\377\200");
		send(ACT_DICT, 4'd5, 1'b0, 3'd7, 8'hff);

		// directed: pass-through with no entries, then matches
		send(ACT_FLUSH, '0, '0, '0, '0);
		send(ACT_CHAR, '0, '0, '0, 8'h00);
		send(ACT_CHAR, '0, '0, '0, 8'hff);
		send(ACT_FLUSH, '0, '0, '0, '0);
		wait_quiet();
		set_count(16);
		txt = "abcabdcd";
		for (int k = 0; k < txt.len(); k++) send(ACT_CHAR, '0, '0, '0, txt[k]);
		for (int k = 0; k < 8; k++) send(ACT_CHAR, 4'hf, 1'b1, 3'd7, 8'h64);
		send(ACT_CHAR, '0, '0, '0, 8'hff);
		send(ACT_CHAR, '0, '0, '0, 8'h01);
		send(ACT_CHAR, '0, '0, '0, 8'h61);
		send(ACT_NONE, 4'hf, 1'b1, 3'd7, 8'hff);
		send(ACT_FLUSH, '0, '0, '0, '0);

		// random phases over several entry counts
		wait_quiet();
		set_count(31);
		random_phase(50);
		wait_quiet();
		set_count(0);
		random_phase(25);
		wait_quiet();
		idle_pct = 0;
		set_count(3);
		random_phase(35);
		wait_quiet();
		idle_pct = 14;
		set_count(16);
		random_phase(50);

		wait_quiet();
		done = 1;
		if (board.errors == 0 && board.exp_char.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
